/* rtl/core/ili_pkg.sv */
package ili_pkg;

    localparam int DEF_CAPACITY = 64;
    localparam int OP_W         = 3;
    localparam int POS_W        = 16;
    localparam int VAL_W        = 32;
    localparam int LEN_W        = 7;

    localparam logic [VAL_W-1:0] MISS_VALUE = {VAL_W{1'b1}};

    typedef enum logic [OP_W-1:0] {
        OP_GET    = 3'd0,
        OP_HEAD   = 3'd1,
        OP_TAIL   = 3'd2,
        OP_AT     = 3'd3,
        OP_DELETE = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SHIFT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [OP_W-1:0]         operation;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [VAL_W-1:0] read_value;
        logic                    hit;
        logic                    changed;
        logic                    overflow;
        logic [LEN_W-1:0]        length;
    } t_out_item;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic                    ins;
        logic                    del;
        logic                    load;
        logic                    shift;
        logic [POS_W-1:0]        pos;
        logic signed [VAL_W-1:0] value;
    } t_cell_ctrl;

endpackage

/* rtl/core/ili_stream_if.sv */
interface ili_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/indexed_list_insert_delete_core.sv */
// Ordered list of up to CAPACITY signed 32-bit values held in a row of cells.
// Insert at head, append, insert at index and delete shift the cells from
// the target position onward by one place together, so those operations, and
// a get past the end, need no readout pass: the result is registered at the
// accepting edge and the next item is taken in the following cycle once the
// output register is free. A get that hits copies every element into a read
// tap chain and moves the wanted one to cell 0 in log2(CAPACITY) steps, one
// bit of the index a step (CAPACITY defaults to 64). An insert into a full
// list is dropped and flagged with overflow. No clearing pass follows reset;
// only the state, element count, read step and output valid are cleared.
module indexed_list_insert_delete_core #(
    parameter int CAPACITY = ili_pkg::DEF_CAPACITY
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    ili_stream_if.sink         i_in,
    ili_stream_if.source       o_out
);

    localparam int IDXW  = $clog2(CAPACITY);
    localparam int CNTW  = $clog2(CAPACITY + 1);
    localparam int STEPW = (IDXW > 1) ? $clog2(IDXW) : 1;

    localparam logic [CNTW-1:0]  FULL_COUNT = CNTW'(CAPACITY);
    localparam logic [STEPW-1:0] LAST_STEP  = STEPW'(IDXW - 1);

    ili_pkg::t_state    r_state;
    ili_pkg::t_state    n_state;
    logic [CNTW-1:0]    r_count;
    logic [CNTW-1:0]    n_count;
    logic [STEPW-1:0]   r_step;
    logic [IDXW-1:0]    r_pos;
    logic               r_out_valid;
    ili_pkg::t_out_item r_out;
    ili_pkg::t_out_item n_out;
    logic               out_load;
    logic               slot_free;
    logic               in_fire;

    ili_pkg::t_cell_ctrl ctrl;
    ili_pkg::t_op        op;
    logic [ili_pkg::POS_W-1:0] pos;
    logic [ili_pkg::POS_W-1:0] cnt_ext;
    logic [ili_pkg::POS_W-1:0] ins_pos;
    logic               full;
    logic               ins_req;
    logic               ins;
    logic               ovf;
    logic               del;
    logic               get_hit;

    logic signed [ili_pkg::VAL_W-1:0] vals [CAPACITY];
    logic signed [ili_pkg::VAL_W-1:0] taps [CAPACITY];
    logic signed [ili_pkg::VAL_W-1:0] fars [CAPACITY];
    logic signed [ili_pkg::VAL_W-1:0] cand [CAPACITY][IDXW];

    // ---------------------------------------------------------------- decode
    assign op      = ili_pkg::t_op'(i_in.data.operation);
    assign pos     = i_in.data.position;
    assign cnt_ext = ili_pkg::POS_W'(r_count);
    assign full    = (r_count == FULL_COUNT);

    always_comb begin
        ins_req = 1'b0;
        del     = 1'b0;
        get_hit = 1'b0;
        ins_pos = pos;
        unique case (op)
            ili_pkg::OP_GET: begin
                get_hit = (pos < cnt_ext);
            end
            ili_pkg::OP_HEAD: begin
                ins_req = 1'b1;
                ins_pos = '0;
            end
            ili_pkg::OP_TAIL: begin
                ins_req = 1'b1;
                ins_pos = cnt_ext;
            end
            ili_pkg::OP_AT: begin
                ins_req = (pos <= cnt_ext);
            end
            ili_pkg::OP_DELETE: begin
                del = (pos < cnt_ext);
            end
            default: begin
                ins_req = 1'b0;
            end
        endcase
    end

    assign ins = ins_req && !full;
    assign ovf = ins_req && full;

    assign slot_free  = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == ili_pkg::S_IDLE) && slot_free;
    assign in_fire    = i_in.valid && i_in.ready;

    // ------------------------------------------------------------ next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ili_pkg::S_IDLE: begin
                if (in_fire && get_hit) begin
                    n_state = ili_pkg::S_SHIFT;
                end
            end
            ili_pkg::S_SHIFT: begin
                if (r_step == LAST_STEP) begin
                    n_state = ili_pkg::S_OUT;
                end
            end
            ili_pkg::S_OUT: begin
                if (slot_free) begin
                    n_state = ili_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ili_pkg::S_IDLE;
            end
        endcase
    end

    // --------------------------------------------------------------- outputs
    always_comb begin
        ctrl               = '0;
        out_load           = 1'b0;
        n_count            = r_count;
        n_out.read_value   = ili_pkg::MISS_VALUE;
        n_out.hit          = 1'b0;
        n_out.changed      = 1'b0;
        n_out.overflow     = 1'b0;
        n_out.length       = ili_pkg::LEN_W'(r_count);
        unique case (r_state)
            ili_pkg::S_IDLE: begin
                if (in_fire) begin
                    ctrl.ins   = ins;
                    ctrl.del   = del;
                    ctrl.load  = get_hit;
                    ctrl.pos   = ins ? ins_pos : pos;
                    ctrl.value = i_in.data.value;
                    if (ins) begin
                        n_count = r_count + 1'b1;
                    end else if (del) begin
                        n_count = r_count - 1'b1;
                    end
                    out_load       = !get_hit;
                    n_out.changed  = ins || del;
                    n_out.overflow = ovf;
                    n_out.length   = ili_pkg::LEN_W'(n_count);
                end
            end
            ili_pkg::S_SHIFT: begin
                ctrl.shift = r_pos[r_step];
            end
            ili_pkg::S_OUT: begin
                if (slot_free) begin
                    out_load         = 1'b1;
                    n_out.read_value = taps[0];
                    n_out.hit        = 1'b1;
                end
            end
            default: begin
                out_load = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------- registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ili_pkg::S_IDLE;
            r_count     <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (r_state == ili_pkg::S_SHIFT) begin
                r_step <= r_step + 1'b1;
            end else begin
                r_step <= '0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_pos <= IDXW'(pos);
        end
        if (out_load) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // ----------------------------------------------------------- cell chain
    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        logic signed [ili_pkg::VAL_W-1:0] left;
        logic signed [ili_pkg::VAL_W-1:0] right;

        if (gi == 0) begin : g_first
            assign left = '0;
        end else begin : g_mid_l
            assign left = vals[gi-1];
        end
        if (gi == CAPACITY - 1) begin : g_last
            assign right = '0;
        end else begin : g_mid_r
            assign right = vals[gi+1];
        end

        // tap step k pulls from 2**k cells further along
        for (genvar gk = 0; gk < IDXW; gk++) begin : g_far
            localparam int SRC = gi + (1 << gk);
            if (SRC < CAPACITY) begin : g_in
                assign cand[gi][gk] = taps[SRC];
            end else begin : g_out
                assign cand[gi][gk] = '0;
            end
        end
        assign fars[gi] = cand[gi][r_step];

        ili_cell #(
            .IDX (gi)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (ctrl),
            .i_left  (left),
            .i_right (right),
            .i_far   (fars[gi]),
            .o_val   (vals[gi]),
            .o_tap   (taps[gi])
        );
    end

    // ------------------------------------------------------------ assertions
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_COUNT)
        else $error("element count above capacity");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(!i_rst_n) |->
            (r_count == $past(r_count)) || (r_count == $past(r_count) + 1'b1) ||
            (r_count == $past(r_count) - 1'b1))
        else $error("element count moved by more than one");

    a_quick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && !get_hit |=> r_out_valid && (r_state == ili_pkg::S_IDLE))
        else $error("single-cycle operation left no result");

    a_hit_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load && n_out.hit |-> (r_state == ili_pkg::S_OUT))
        else $error("hit result loaded outside readout");

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load && n_out.overflow |-> full && !n_out.changed)
        else $error("overflow flagged on a list with room");

endmodule

/* rtl/core/ili_cell.sv */
module ili_cell #(
    parameter int IDX = 0
) (
    input  logic                            i_clk,
    input  ili_pkg::t_cell_ctrl             i_ctrl,
    input  logic signed [ili_pkg::VAL_W-1:0] i_left,
    input  logic signed [ili_pkg::VAL_W-1:0] i_right,
    input  logic signed [ili_pkg::VAL_W-1:0] i_far,
    output logic signed [ili_pkg::VAL_W-1:0] o_val,
    output logic signed [ili_pkg::VAL_W-1:0] o_tap
);

    localparam logic [ili_pkg::POS_W-1:0] MY_POS = ili_pkg::POS_W'(IDX);

    logic signed [ili_pkg::VAL_W-1:0] r_val;
    logic signed [ili_pkg::VAL_W-1:0] n_val;
    logic signed [ili_pkg::VAL_W-1:0] r_tap;
    logic signed [ili_pkg::VAL_W-1:0] n_tap;

    always_comb begin
        n_val = r_val;
        if (i_ctrl.ins) begin
            if (MY_POS == i_ctrl.pos) begin
                n_val = i_ctrl.value;
            end else if (MY_POS > i_ctrl.pos) begin
                n_val = i_left;
            end
        end else if (i_ctrl.del) begin
            if (MY_POS >= i_ctrl.pos) begin
                n_val = i_right;
            end
        end
    end

    // read tap: loaded from the element, then moved towards cell 0
    always_comb begin
        n_tap = r_tap;
        if (i_ctrl.load) begin
            n_tap = r_val;
        end else if (i_ctrl.shift) begin
            n_tap = i_far;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        r_tap <= n_tap;
    end

    assign o_val = r_val;
    assign o_tap = r_tap;

endmodule
